// File: design/true_peak_limiter_assert.svh
// Assertion macros used by the checker file tpl_checker.sv.
`ifndef TRUE_PEAK_LIMITER_ASSERT_SVH
`define TRUE_PEAK_LIMITER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TPL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define TPL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: design/tpl_pkg.sv
// ----------------------------------------------------------------------------
// tpl_pkg
// Shared types and register indexes of the true-peak limiter.
// ----------------------------------------------------------------------------
package tpl_pkg;
    localparam int unsigned RegCeiling = 0;
    localparam int unsigned RegAttack  = 1;
    localparam int unsigned RegRelease = 2;
    localparam int unsigned RegMix     = 3;
    localparam int unsigned MixOne     = 65536;
    localparam int unsigned MixWidth   = 17;

    typedef enum logic [2:0] {
        t_ST_IDLE, t_ST_PEAK, t_ST_DIV, t_ST_SMOOTH, t_ST_GAIN, t_ST_MIX, t_ST_OUT
    } t_state;
endpackage

// File: design/true_peak_limiter.sv
// An accepted request passes the front queue and the peak, smoothing, gain, mix and
// output states of the back; a divide state is added whenever the ceiling forces a divide.
// The back works on one job at a time and takes the next only after its result is buffered.
// A sample with look-ahead yields its result only when the next sample arrives.
// Reset is synchronous, active low: registers to defaults, gain to unity.
// ----------------------------------------------------------------------------
// true_peak_limiter
// Mono true-peak limiter with 4x linear interpolated peak detection.
// ----------------------------------------------------------------------------
module true_peak_limiter import tpl_pkg::*; #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEFF_WIDTH  = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic                           i_block_end,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_out_block_end,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    logic [SAMPLE_WIDTH-1:0] r_ceiling;
    logic [COEFF_WIDTH-1:0]  r_attack, r_release;
    logic [MixWidth-1:0]     r_mix;
    logic                    job_valid, job_use, job_last, job_take;
    logic signed [SAMPLE_WIDTH-1:0] job_dry, job_next;
    logic [1:0]              ridx;

    // Registers sit on 4-byte boundaries; the write happens at the access cycle.
    assign pready = 1'b1;
    assign ridx   = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= SAMPLE_WIDTH'(8388608);
            r_attack  <= COEFF_WIDTH'(16742301);
            r_release <= COEFF_WIDTH'(16770227);
            r_mix     <= MixWidth'(MixOne);
        end else if (psel && penable && pwrite) begin
            case (ridx)
                2'(RegCeiling): r_ceiling <= pwdata[SAMPLE_WIDTH-1:0];
                2'(RegAttack):  r_attack  <= pwdata[COEFF_WIDTH-1:0];
                2'(RegRelease): r_release <= pwdata[COEFF_WIDTH-1:0];
                2'(RegMix):     r_mix     <= pwdata[MixWidth-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            2'(RegCeiling): prdata = 32'(r_ceiling);
            2'(RegAttack):  prdata = 32'(r_attack);
            2'(RegRelease): prdata = 32'(r_release);
            2'(RegMix):     prdata = 32'(r_mix);
            default:        prdata = '0;
        endcase
    end

    // The front holds the look-ahead sample and queues up to two jobs.
    tpl_front #(.SW(SAMPLE_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_sample(i_sample_in), .i_last(i_block_end),
        .o_job_valid(job_valid), .o_job_dry(job_dry), .o_job_next(job_next),
        .o_job_use_next(job_use), .o_job_last(job_last), .i_job_take(job_take)
    );

    // The back computes one result at a time into a one-entry output buffer.
    tpl_back #(.SW(SAMPLE_WIDTH), .CW(COEFF_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .i_job_dry(job_dry), .i_job_next(job_next),
        .i_job_use_next(job_use), .i_job_last(job_last), .o_job_take(job_take),
        .i_ceiling(r_ceiling), .i_attack(r_attack), .i_release(r_release),
        .i_mix(r_mix), .o_empty(empty), .i_pop(pop),
        .o_sample(o_sample_out), .o_last(o_out_block_end)
    );
endmodule

// File: design/tpl_front.sv
// ----------------------------------------------------------------------------
// tpl_front
// Holds one sample of look-ahead and issues jobs into a two-entry queue.
// ----------------------------------------------------------------------------
module tpl_front import tpl_pkg::*; #(
    parameter int SW = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic signed [SW-1:0] i_sample,
    input  logic                 i_last,
    output logic                 o_job_valid,
    output logic signed [SW-1:0] o_job_dry,
    output logic signed [SW-1:0] o_job_next,
    output logic                 o_job_use_next,
    output logic                 o_job_last,
    input  logic                 i_job_take
);
    localparam int JW = 2*SW + 2;
    logic [JW-1:0]        r_q [2];
    logic [1:0]           r_cnt, n_cnt;
    logic                 r_rd, r_wr;
    logic                 r_hv;
    logic signed [SW-1:0] r_hs;
    logic                 acc;
    logic [1:0]           nwr;
    logic [JW-1:0]        j0, j1;

    // An item may create two jobs, so it needs an empty queue.
    assign o_full = (r_cnt != 2'd0);
    assign acc    = i_push && !o_full;
    assign j0 = {r_hs, i_sample, 1'b1, 1'b0};
    assign j1 = {i_sample, {SW{1'b0}}, 1'b0, 1'b1};
    assign nwr = acc ? ({1'b0, r_hv} + {1'b0, i_last}) : 2'd0;
    assign n_cnt = r_cnt + nwr - {1'b0, i_job_take};

    assign o_job_valid = (r_cnt != 2'd0);
    assign {o_job_dry, o_job_next, o_job_use_next, o_job_last} = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_hv  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_job_take) begin
                r_rd <= ~r_rd;
            end
            if (acc) begin
                if (r_hv && i_last) begin
                    r_q[r_wr]  <= j0;
                    r_q[~r_wr] <= j1;
                end else if (r_hv) begin
                    r_q[r_wr] <= j0;
                end else if (i_last) begin
                    r_q[r_wr] <= j1;
                end
                r_wr <= r_wr ^ nwr[0];
                r_hv <= !i_last;
                r_hs <= i_sample;
            end
        end
    end
endmodule

// File: design/tpl_div.sv
// ----------------------------------------------------------------------------
// tpl_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpl_div #(
    parameter int NW = 48,
    parameter int DW = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   sh, df;

    assign sh = {r_rem[DW-1:0], r_q[NW-1]};
    assign df = sh - {1'b0, r_den};
    assign o_quot = r_q;
    assign o_done = r_busy && (r_cnt == CW'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (r_cnt == CW'(0)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CW'(1);
                if (!df[DW]) begin
                    r_rem <= df;
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= sh;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
            end
        end
    end
endmodule

// File: design/tpl_back.sv
// ----------------------------------------------------------------------------
// tpl_back
// Sequencer: peak search, gain divide, smoothing, gain and mix, one-entry result buffer.
// ----------------------------------------------------------------------------
module tpl_back import tpl_pkg::*; #(
    parameter int SW = 24,
    parameter int CW = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  logic signed [SW-1:0] i_job_dry,
    input  logic signed [SW-1:0] i_job_next,
    input  logic                 i_job_use_next,
    input  logic                 i_job_last,
    output logic                 o_job_take,
    input  logic [SW-1:0]        i_ceiling,
    input  logic [CW-1:0]        i_attack,
    input  logic [CW-1:0]        i_release,
    input  logic [MixWidth-1:0]  i_mix,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic signed [SW-1:0] o_sample,
    output logic                 o_last
);
    localparam int GW = CW + 1;
    localparam int NW = SW + CW;
    localparam logic [GW-1:0] GainOne = GW'(1) << CW;

    t_state r_st, n_st;
    logic signed [SW-1:0] r_dry;
    logic signed [SW:0]   r_nx;
    logic                 r_use, r_last;
    logic [1:0]           r_k;
    logic [SW:0]          r_peak;
    logic [GW-1:0]        r_tgt, r_g;
    logic signed [SW+GW:0] r_lim;
    logic signed [SW-1:0] r_obuf;
    logic                 r_olast, r_ofull;
    logic                 div_start, div_done;
    logic [NW-1:0]        div_q;
    logic signed [SW+1:0] diff;
    logic signed [SW+3:0] kd;
    logic signed [SW+3:0] interp;
    logic [SW+3:0]        mag;
    logic [GW-1:0]        coeff_x, dg;
    logic [2*GW-1:0]      prod;
    logic [MixWidth-1:0]  mixv;
    logic signed [SW+GW+MixWidth+1:0] mixp;

    tpl_div #(.NW(NW), .DW(SW+1)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num({i_ceiling, {CW{1'b0}}}), .i_den(r_peak),
        .o_done(div_done), .o_quot(div_q)
    );

    assign diff   = (SW+2)'(r_nx) - (SW+2)'(r_dry);
    assign kd     = (SW+4)'(diff) * $signed({2'b00, r_k});
    assign interp = (SW+4)'(r_dry) + (kd >>> 2);
    assign mag    = interp[SW+3] ? -interp : interp;
    assign coeff_x = {1'b0, (r_tgt < r_g) ? i_attack : i_release};
    assign dg     = (r_g >= r_tgt) ? (r_g - r_tgt) : (r_tgt - r_g);
    assign prod   = coeff_x * dg;
    assign mixv   = (i_mix > MixWidth'(MixOne)) ? MixWidth'(MixOne) : i_mix;
    assign mixp   = $signed({1'b0, mixv}) * ((SW+GW+1)'(r_lim) - (SW+GW+1)'(r_dry));

    assign o_empty  = !r_ofull;
    assign o_sample = r_obuf;
    assign o_last   = r_olast;
    assign o_job_take = (r_st == t_ST_IDLE) && i_job_valid;
    // With look-ahead the step index runs 1, 2, 3 and wraps to 0, so the peak
    // holds all three interpolations by the time the divide is decided.
    assign div_start  = (r_st == t_ST_PEAK) && (r_k == 2'd0 || !r_use) &&
                        (i_ceiling != '0) && ((SW+1)'(i_ceiling) < r_peak);

    always_comb begin
        n_st = r_st;
        case (r_st)
            t_ST_IDLE:   if (i_job_valid) n_st = t_ST_PEAK;
            t_ST_PEAK:   if (r_k == 2'd0 || !r_use) n_st = div_start ? t_ST_DIV : t_ST_SMOOTH;
            t_ST_DIV:    if (div_done) n_st = t_ST_SMOOTH;
            t_ST_SMOOTH: n_st = t_ST_GAIN;
            t_ST_GAIN:   n_st = t_ST_MIX;
            t_ST_MIX:    n_st = t_ST_OUT;
            t_ST_OUT:    if (!r_ofull || i_pop) n_st = t_ST_IDLE;
            default:     n_st = t_ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= t_ST_IDLE;
            r_g     <= GainOne;
            r_ofull <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == t_ST_OUT && (!r_ofull || i_pop)) begin
                r_ofull <= 1'b1;
            end else if (i_pop && r_ofull) begin
                r_ofull <= 1'b0;
            end
            case (r_st)
                t_ST_IDLE: begin
                    r_dry  <= i_job_dry;
                    r_nx   <= (SW+1)'(i_job_next);
                    r_use  <= i_job_use_next;
                    r_last <= i_job_last;
                    r_k    <= 2'd1;
                    r_peak <= i_job_dry[SW-1] ? -(SW+1)'(i_job_dry) : (SW+1)'(i_job_dry);
                    r_tgt  <= GainOne;
                end
                t_ST_PEAK: begin
                    if (r_use) begin
                        if ((SW+4)'(r_peak) < mag) r_peak <= (SW+1)'(mag);
                        r_k <= r_k + 2'd1;
                    end
                end
                t_ST_DIV: if (div_done) r_tgt <= GW'(div_q);
                t_ST_SMOOTH: begin
                    if (r_g >= r_tgt) r_g <= r_tgt + GW'(prod >> CW);
                    else r_g <= r_tgt - GW'((prod + (2*GW)'(GainOne - 1'b1)) >> CW);
                end
                t_ST_GAIN: r_lim <= ($signed({1'b0, r_g}) * r_dry) >>> CW;
                t_ST_MIX:  r_lim <= (SW+GW+1)'((SW+GW+MixWidth+2)'(r_dry) + (mixp >>> 16));
                t_ST_OUT: begin
                    if (!r_ofull || i_pop) begin
                        r_obuf  <= SW'(r_lim);
                        r_olast <= r_last;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// File: design/tpl_checker.sv
// ----------------------------------------------------------------------------
// tpl_checker
// Port-level checks of the true-peak limiter.
// ----------------------------------------------------------------------------
`include "true_peak_limiter_assert.svh"
module tpl_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic push,
    input logic full,
    input logic i_block_end,
    input logic empty,
    input logic pop,
    input logic pready
);
    `TPL_ASSERT_IMP(a_ready, 1'b1, pready)
    `TPL_ASSERT_NEXT(a_full_after_end, push && !full && i_block_end, full)
    `TPL_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty)
endmodule

bind true_peak_limiter tpl_checker u_tpl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
    .i_block_end(i_block_end), .empty(empty), .pop(pop), .pready(pready)
);
